### hdl/gwrt_pkg.sv
// ----------------------------------------------------------------------------
// gwrt_pkg
// Shared widths, opcodes, controller/datapath interface structs and the
// packed result word of the group-of-pictures window tracker.
// ----------------------------------------------------------------------------
package gwrt_pkg;

    localparam int PTS_W     = 48;
    localparam int PKT_W     = 24;
    localparam int CLIP_W    = 16;
    localparam int WIN_W     = 16;
    localparam int ID_W      = 16;
    localparam int BYTE_W    = 40;
    localparam int CNT_W     = 7;
    localparam int TOUT_W    = 48;
    localparam int PROD_W    = 36;
    localparam int PAD_W     = 7;
    localparam int CNT_MAX   = 127;
    localparam int MICROS_PER_SEC = 1_000_000;

    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 208;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd30;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_SNAP  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } gwrt_op_t;

    // head reads (oldest bytes, second start) use the default read addresses
    typedef struct packed {
        logic in_load;
        logic rd_newest;
        logic rd_snap;
        logic do_force;
        logic do_open;
        logic do_extend;
        logic do_evict;
        logic do_clear;
        logic snap_init;
        logic snap_step;
        logic snap_take;
        logic snap_oldest;
    } gwrt_cmd_t;

    typedef struct packed {
        gwrt_op_t op;
        logic     opens;
        logic     empty;
        logic     full;
        logic     multi;
        logic     evict_ok;
        logic     clip_in_range;
        logic     snap_hit;
        logic     k_zero;
    } gwrt_status_t;

    // first member is the top of the word: fields run from accepted upward
    typedef struct packed {
        logic [PAD_W-1:0]  pad;
        logic [CNT_W-1:0]  group_count;
        logic [BYTE_W-1:0] total_bytes;
        logic [TOUT_W-1:0] span_us;
        logic [TOUT_W-1:0] clip_start_us;
        logic [ID_W-1:0]   last_group_id;
        logic [ID_W-1:0]   first_group_id;
        logic              clip_valid;
        logic              forced_drop;
        logic [CNT_W-1:0]  evicted_count;
        logic [ID_W-1:0]   group_id;
        logic              accepted;
    } gwrt_result_t;

endpackage

### hdl/gwrt_ring_mem.sv
// ----------------------------------------------------------------------------
// gwrt_ring_mem
// Per-slot group records: start time, end time and byte count. One write
// port shared by all three arrays, registered reads on two addresses.
// ----------------------------------------------------------------------------
module gwrt_ring_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int TW    = 48,
    parameter int BW    = 40
) (
    input  logic          aclk,
    input  logic [AW-1:0] wr_addr,
    input  logic          we_start,
    input  logic          we_eb,
    input  logic [TW-1:0] wr_start,
    input  logic [TW-1:0] wr_end,
    input  logic [BW-1:0] wr_bytes,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [TW-1:0] rd_start,
    output logic [TW-1:0] rd_end,
    output logic [BW-1:0] rd_bytes
);

    logic [TW-1:0] start_mem [DEPTH];
    logic [TW-1:0] end_mem   [DEPTH];
    logic [BW-1:0] bytes_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we_start) begin
            start_mem[wr_addr] <= wr_start;
        end
        rd_start <= start_mem[rd_addr_a];
    end

    always_ff @(posedge aclk) begin
        if (we_eb) begin
            end_mem[wr_addr] <= wr_end;
        end
        rd_end <= end_mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (we_eb) begin
            bytes_mem[wr_addr] <= wr_bytes;
        end
        rd_bytes <= bytes_mem[rd_addr_b];
    end

endmodule

### hdl/gwrt_datapath.sv
// ----------------------------------------------------------------------------
// gwrt_datapath
// Ring pointers, byte total, window scaling, eviction and snapshot compares,
// and the record memory. Executes the controller's commands one per cycle.
// ----------------------------------------------------------------------------
module gwrt_datapath #(
    parameter int MAX_GROUPS = 64,
    parameter int TIME_BITS  = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [gwrt_pkg::WIN_W-1:0]    cfg_wr_data,
    input  gwrt_pkg::gwrt_op_t            in_opcode,
    input  logic                          in_video,
    input  logic                          in_key,
    input  logic [gwrt_pkg::PTS_W-1:0]    in_pts,
    input  logic [gwrt_pkg::PKT_W-1:0]    in_bytes,
    input  logic [gwrt_pkg::CLIP_W-1:0]   in_clip,
    input  gwrt_pkg::gwrt_cmd_t           cmd,
    output gwrt_pkg::gwrt_status_t        status,
    output gwrt_pkg::gwrt_result_t        result
);

    import gwrt_pkg::*;

    localparam int SW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CW  = $clog2(MAX_GROUPS + 1);
    localparam int CW1 = CW + 1;
    localparam int TW  = TIME_BITS;

    function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base,
                                              input logic [CW-1:0] k);
        logic [CW1-1:0] s;
        s = CW1'(base) + CW1'(k);
        if (s >= CW1'(MAX_GROUPS)) begin
            s = s - CW1'(MAX_GROUPS);
        end
        return s[SW-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] sat_add(input logic [BYTE_W-1:0] a,
                                                  input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[BYTE_W] ? {BYTE_W{1'b1}} : s[BYTE_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CW-1:0] v);
        return (32'(v) > 32'(CNT_MAX)) ? CNT_W'(CNT_MAX) : CNT_W'(v);
    endfunction

    // configuration and latched item
    logic [WIN_W-1:0]  window_reg, window_next;
    gwrt_op_t          op_reg;
    logic              opens_reg;
    logic [TW-1:0]     pts_reg;
    logic [PKT_W-1:0]  pbytes_reg;
    logic [CLIP_W-1:0] clip_sec_reg;
    logic [PROD_W-1:0] cap_reg, clip_us_reg;

    // ring state
    logic [SW-1:0]     oldest_slot_reg, oldest_slot_next;
    logic [CW-1:0]     held_reg, held_next;
    logic [BYTE_W-1:0] byte_total_reg, byte_total_next;
    logic [ID_W-1:0]   oldest_id_reg, oldest_id_next;
    logic [TW-1:0]     newest_end_reg, newest_end_next;
    logic [TW-1:0]     oldest_start_reg, oldest_start_next;

    // per-item result and walk state
    logic              acc_reg, acc_next;
    logic              forced_reg, forced_next;
    logic              clip_valid_reg, clip_valid_next;
    logic [CW-1:0]     evicted_reg, evicted_next;
    logic [CW-1:0]     first_reg, first_next;
    logic [TW-1:0]     clip_start_reg, clip_start_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [TW-1:0]     cutoff_reg, cutoff_next;

    // memory ports
    logic [SW-1:0]     wr_addr, rd_addr_a, rd_addr_b, newest_slot;
    logic [TW-1:0]     rd_start, rd_end, ext_end, wr_end;
    logic [BYTE_W-1:0] rd_bytes, wr_bytes, pbytes_ext;
    logic [TW-1:0]     head_diff;
    logic [ID_W-1:0]   newest_id;

    assign newest_slot = slot_of(oldest_slot_reg, held_reg - CW'(1));
    assign pbytes_ext  = BYTE_W'(pbytes_reg);
    assign ext_end     = (pts_reg > rd_end) ? pts_reg : rd_end;
    assign wr_end      = cmd.do_open ? pts_reg : ext_end;
    assign wr_bytes    = cmd.do_open ? pbytes_ext : sat_add(rd_bytes, pbytes_ext);
    assign wr_addr     = cmd.do_open ? slot_of(oldest_slot_reg, held_reg) : newest_slot;
    assign rd_addr_a   = cmd.rd_snap ? slot_of(oldest_slot_reg, k_reg)
                                     : slot_of(oldest_slot_reg, CW'(1));
    assign rd_addr_b   = cmd.rd_newest ? newest_slot : oldest_slot_reg;

    gwrt_ring_mem #(
        .DEPTH (MAX_GROUPS),
        .AW    (SW),
        .TW    (TW),
        .BW    (BYTE_W)
    ) u_mem (
        .aclk      (aclk),
        .wr_addr   (wr_addr),
        .we_start  (cmd.do_open),
        .we_eb     (cmd.do_open | cmd.do_extend),
        .wr_start  (pts_reg),
        .wr_end    (wr_end),
        .wr_bytes  (wr_bytes),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_start  (rd_start),
        .rd_end    (rd_end),
        .rd_bytes  (rd_bytes)
    );

    // rd_start holds the second group's start while checking eviction
    assign head_diff = newest_end_reg - rd_start;

    always_comb begin
        status.op            = op_reg;
        status.opens         = opens_reg;
        status.empty         = (held_reg == '0);
        status.full          = (held_reg == CW'(MAX_GROUPS));
        status.multi         = (held_reg > CW'(1));
        status.evict_ok      = (newest_end_reg >= rd_start) &&
                               (64'(head_diff) >= 64'(cap_reg));
        status.clip_in_range = (64'(clip_us_reg) <= 64'(newest_end_reg));
        status.snap_hit      = (rd_start <= cutoff_reg);
        status.k_zero        = (k_reg == '0);
    end

    always_comb begin
        window_next       = cfg_wr_en ? cfg_wr_data : window_reg;
        oldest_slot_next  = oldest_slot_reg;
        held_next         = held_reg;
        byte_total_next   = byte_total_reg;
        oldest_id_next    = oldest_id_reg;
        newest_end_next   = newest_end_reg;
        oldest_start_next = oldest_start_reg;
        acc_next          = acc_reg;
        forced_next       = forced_reg;
        clip_valid_next   = clip_valid_reg;
        evicted_next      = evicted_reg;
        first_next        = first_reg;
        clip_start_next   = clip_start_reg;
        k_next            = k_reg;
        cutoff_next       = cutoff_reg;

        if (cmd.in_load) begin
            acc_next        = 1'b0;
            forced_next     = 1'b0;
            clip_valid_next = 1'b0;
            evicted_next    = '0;
            first_next      = '0;
        end

        // drop the oldest group; rd_bytes/rd_start hold its bytes and the next start
        if (cmd.do_force || cmd.do_evict) begin
            byte_total_next   = (byte_total_reg >= rd_bytes) ? byte_total_reg - rd_bytes
                                                             : '0;
            oldest_slot_next  = slot_of(oldest_slot_reg, CW'(1));
            held_next         = held_reg - CW'(1);
            oldest_id_next    = oldest_id_reg + ID_W'(1);
            oldest_start_next = rd_start;
            evicted_next      = evicted_reg + CW'(1);
            if (cmd.do_force) begin
                forced_next = 1'b1;
            end
        end

        if (cmd.do_open) begin
            held_next       = held_reg + CW'(1);
            byte_total_next = sat_add(byte_total_reg, pbytes_ext);
            newest_end_next = pts_reg;
            acc_next        = 1'b1;
            if (held_reg == '0) begin
                oldest_start_next = pts_reg;
            end
        end

        if (cmd.do_extend) begin
            newest_end_next = ext_end;
            byte_total_next = sat_add(byte_total_reg, pbytes_ext);
            acc_next        = 1'b1;
        end

        if (cmd.do_clear) begin
            oldest_id_next   = oldest_id_reg + ID_W'(held_reg);
            oldest_slot_next = '0;
            held_next        = '0;
            byte_total_next  = '0;
        end

        if (cmd.snap_init) begin
            k_next      = held_reg - CW'(1);
            cutoff_next = TW'(64'(newest_end_reg) - 64'(clip_us_reg));
        end

        if (cmd.snap_step) begin
            k_next = k_reg - CW'(1);
        end

        if (cmd.snap_take) begin
            clip_valid_next = 1'b1;
            first_next      = k_reg;
            clip_start_next = rd_start;
        end

        if (cmd.snap_oldest) begin
            clip_valid_next = 1'b1;
            first_next      = '0;
            clip_start_next = oldest_start_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg      <= WINDOW_RESET;
            oldest_slot_reg <= '0;
            held_reg        <= '0;
            byte_total_reg  <= '0;
            oldest_id_reg   <= '0;
            acc_reg         <= 1'b0;
            forced_reg      <= 1'b0;
            clip_valid_reg  <= 1'b0;
            evicted_reg     <= '0;
        end else begin
            window_reg      <= window_next;
            oldest_slot_reg <= oldest_slot_next;
            held_reg        <= held_next;
            byte_total_reg  <= byte_total_next;
            oldest_id_reg   <= oldest_id_next;
            acc_reg         <= acc_next;
            forced_reg      <= forced_next;
            clip_valid_reg  <= clip_valid_next;
            evicted_reg     <= evicted_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            op_reg       <= in_opcode;
            opens_reg    <= in_video & in_key;
            pts_reg      <= TW'(in_pts);
            pbytes_reg   <= in_bytes;
            clip_sec_reg <= in_clip;
        end
        cap_reg          <= PROD_W'(window_reg) * PROD_W'(MICROS_PER_SEC);
        clip_us_reg      <= PROD_W'(clip_sec_reg) * PROD_W'(MICROS_PER_SEC);
        newest_end_reg   <= newest_end_next;
        oldest_start_reg <= oldest_start_next;
        first_reg        <= first_next;
        clip_start_reg   <= clip_start_next;
        k_reg            <= k_next;
        cutoff_reg       <= cutoff_next;
    end

    assign newest_id = oldest_id_reg + ID_W'(held_reg) - ID_W'(1);

    always_comb begin
        result                = '0;
        result.accepted       = acc_reg;
        result.group_id       = acc_reg ? newest_id : '0;
        result.evicted_count  = sat_cnt(evicted_reg);
        result.forced_drop    = forced_reg;
        result.clip_valid     = clip_valid_reg;
        result.first_group_id = clip_valid_reg ? oldest_id_reg + ID_W'(first_reg) : '0;
        result.last_group_id  = clip_valid_reg ? newest_id : '0;
        result.clip_start_us  = clip_valid_reg ? TOUT_W'(clip_start_reg) : '0;
        if (held_reg != '0 && newest_end_reg >= oldest_start_reg) begin
            result.span_us = TOUT_W'(newest_end_reg - oldest_start_reg);
        end
        result.total_bytes    = byte_total_reg;
        result.group_count    = sat_cnt(held_reg);
    end

endmodule

### hdl/gwrt_ctrl.sv
// ----------------------------------------------------------------------------
// gwrt_ctrl
// Sequencer for push, snapshot and clear: issues memory reads, eviction
// steps and the backward snapshot walk, then hands the result word out.
// ----------------------------------------------------------------------------
module gwrt_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   out_free,
    input  gwrt_pkg::gwrt_status_t status,
    output gwrt_pkg::gwrt_cmd_t    cmd,
    output logic                   s_ready,
    output logic                   res_load
);

    import gwrt_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_DECODE   = 11'b000_0000_0010,
        ST_FORCE    = 11'b000_0000_0100,
        ST_OPEN     = 11'b000_0000_1000,
        ST_EXTEND   = 11'b000_0001_0000,
        ST_EV_RD    = 11'b000_0010_0000,
        ST_EV_CHK   = 11'b000_0100_0000,
        ST_SN_START = 11'b000_1000_0000,
        ST_SN_RD    = 11'b001_0000_0000,
        ST_SN_CHK   = 11'b010_0000_0000,
        ST_RESULT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        res_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (status.op)
                    OP_PUSH: begin
                        if (status.opens) begin
                            if (status.full) begin
                                state_next = ST_FORCE;
                            end else begin
                                state_next = ST_OPEN;
                            end
                        end else if (status.empty) begin
                            state_next = ST_RESULT;
                        end else begin
                            cmd.rd_newest = 1'b1;
                            state_next    = ST_EXTEND;
                        end
                    end
                    OP_SNAP: begin
                        state_next = status.empty ? ST_RESULT : ST_SN_START;
                    end
                    OP_CLEAR: begin
                        cmd.do_clear = 1'b1;
                        state_next   = ST_RESULT;
                    end
                    OP_NOP: begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_FORCE: begin
                cmd.do_force = 1'b1;
                state_next   = ST_OPEN;
            end
            ST_OPEN: begin
                cmd.do_open = 1'b1;
                state_next  = ST_EV_RD;
            end
            ST_EXTEND: begin
                cmd.do_extend = 1'b1;
                state_next    = ST_EV_RD;
            end
            ST_EV_RD: begin
                if (status.multi) begin
                    state_next = ST_EV_CHK;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_EV_CHK: begin
                if (status.evict_ok) begin
                    cmd.do_evict = 1'b1;
                    state_next   = ST_EV_RD;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_SN_START: begin
                // a duration past the newest end reaches before time zero
                if (status.clip_in_range) begin
                    cmd.snap_init = 1'b1;
                    state_next    = ST_SN_RD;
                end else begin
                    cmd.snap_oldest = 1'b1;
                    state_next      = ST_RESULT;
                end
            end
            ST_SN_RD: begin
                cmd.rd_snap = 1'b1;
                state_next  = ST_SN_CHK;
            end
            ST_SN_CHK: begin
                priority if (status.snap_hit) begin
                    cmd.snap_take = 1'b1;
                    state_next    = ST_RESULT;
                end else if (status.k_zero) begin
                    cmd.snap_oldest = 1'b1;
                    state_next      = ST_RESULT;
                end else begin
                    cmd.snap_step = 1'b1;
                    state_next    = ST_SN_RD;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/gop_window_ring_tracker.sv
// ----------------------------------------------------------------------------
// gop_window_ring_tracker
// Ring of group-of-pictures records for a replay window: push packets,
// query the id range of a clip, clear.
// ----------------------------------------------------------------------------
// One command word is worked on at a time; a finished result sits in an
// output register, so the next word is taken while the result waits. A
// push that opens a group is decoded, forces the oldest group out when the
// ring is full, then writes the new group; one that extends reads and then
// updates the newest group. Both then check for eviction while more than
// one group is held, until the retention window evicts no more. A push
// dropped for lack of an open group, a snapshot of an empty ring, clear and
// the unused opcode go from decode straight to the result. A snapshot whose
// duration reaches before time zero takes the oldest group; otherwise it
// walks back from the newest group. The controller is idle again in the
// cycle after the result is loaded, and a held-off output register stalls
// the result load. Every eviction check and walk step has a state for the
// record memory's registered read and one for the compare. A window_seconds
// write takes effect through window_reg and cap_reg, so a push in progress
// can see it. No clearing pass follows reset; only live records are used.
// ----------------------------------------------------------------------------
module gop_window_ring_tracker #(
    parameter int MAX_GROUPS = 64,
    parameter int TIME_BITS  = 48
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic [gwrt_pkg::WIN_W-1:0]         cfg_wr_data,   // window_seconds

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pts_us[47:0], packet_bytes[71:48], clip_seconds[87:72]
    input  logic [gwrt_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // opcode[1:0], is_video[2], is_keyframe[3]
    input  logic [gwrt_pkg::S_TUSER_W-1:0]     s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // accepted[0], group_id[16:1], evicted_count[23:17], forced_drop[24],
    // clip_valid[25], first_group_id[41:26], last_group_id[57:42],
    // clip_start_us[105:58], span_us[153:106], total_bytes[193:154],
    // group_count[200:194], zero pad[207:201]
    output logic [gwrt_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

    import gwrt_pkg::*;

    gwrt_cmd_t    cmd;
    gwrt_status_t status;
    gwrt_result_t result;
    logic         res_load;
    logic         out_free;
    logic         m_valid_reg, m_valid_next;
    gwrt_result_t m_data_reg;

    gwrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .s_ready  (s_axis_tready),
        .res_load (res_load)
    );

    gwrt_datapath #(
        .MAX_GROUPS (MAX_GROUPS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_opcode   (gwrt_op_t'(s_axis_tuser[1:0])),
        .in_video    (s_axis_tuser[2]),
        .in_key      (s_axis_tuser[3]),
        .in_pts      (s_axis_tdata[PTS_W-1:0]),
        .in_bytes    (s_axis_tdata[PTS_W+PKT_W-1:PTS_W]),
        .in_clip     (s_axis_tdata[PTS_W+PKT_W+CLIP_W-1:PTS_W+PKT_W]),
        .cmd         (cmd),
        .status      (status),
        .result      (result)
    );

    // output word register: free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_data_reg <= result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
